// ===== hdl/bleadp_pkg.sv =====
// ----------------------------------------------------------------------------
// bleadp_pkg
// Shared types and constants for the advertising data parser.
// ----------------------------------------------------------------------------
package bleadp_pkg;

    // AD structure types of interest
    localparam logic [7:0] AD_TYPE_FLAGS      = 8'h01;
    localparam logic [7:0] AD_TYPE_UUID16_INC = 8'h02;
    localparam logic [7:0] AD_TYPE_UUID16_ALL = 8'h03;
    localparam logic [7:0] AD_TYPE_MAKER      = 8'hFF;

    // result kinds
    localparam logic KIND_UUID    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // width of the packed result tdata (34 bits of fields, padded to bytes)
    localparam int RES_TDATA_W = 40;

    typedef struct packed {
        logic        kind;
        logic [15:0] uuid_value;
        logic        connectable;
        logic        company_valid;
        logic [15:0] company_id;
        logic        end_of_payload;
    } t_result;

    // results produced by one byte: 0, 1 or 2, slot 0 first
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// ===== hdl/bleadp_walker.sv =====
// ----------------------------------------------------------------------------
// bleadp_walker
// Length-type-value walk state; consumes one payload byte per i_go and
// reports the UUID and summary results it causes.
// ----------------------------------------------------------------------------
module bleadp_walker #(
    parameter int PAYLOAD_MAX = 255
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [7:0]          i_data,
    input  logic [7:0]          i_plen,
    input  logic                i_first,
    output bleadp_pkg::t_push   o_push
);

    localparam logic [7:0] PLEN_MAX = 8'(PAYLOAD_MAX);

    logic [7:0]  r_byte_index,  n_byte_index;
    logic [7:0]  r_total_len,   n_total_len;
    logic [7:0]  r_struct_start, n_struct_start;
    logic [7:0]  r_struct_len,  n_struct_len;
    logic [7:0]  r_struct_type, n_struct_type;
    logic [7:0]  r_low_hold,    n_low_hold;
    logic        r_stopped,     n_stopped;
    logic        r_flags_seen,  n_flags_seen;
    logic        r_conn,        n_conn;
    logic        r_maker_seen,  n_maker_seen;
    logic        r_id_valid,    n_id_valid;
    logic [15:0] r_maker_id,    n_maker_id;

    always_comb begin
        logic [7:0] p;
        logic [7:0] rel;
        logic [7:0] typ;
        logic [7:0] pairs;
        logic [8:0] two_pairs;
        logic       uuid_hit;
        logic       sum_hit;
        bleadp_pkg::t_result uuid_res;
        bleadp_pkg::t_result sum_res;

        n_byte_index   = r_byte_index;
        n_total_len    = r_total_len;
        n_struct_start = r_struct_start;
        n_struct_len   = r_struct_len;
        n_struct_type  = r_struct_type;
        n_low_hold     = r_low_hold;
        n_stopped      = r_stopped;
        n_flags_seen   = r_flags_seen;
        n_conn         = r_conn;
        n_maker_seen   = r_maker_seen;
        n_id_valid     = r_id_valid;
        n_maker_id     = r_maker_id;
        uuid_hit       = 1'b0;
        sum_hit        = 1'b0;
        uuid_res       = '0;
        sum_res        = '0;
        p              = '0;
        rel            = '0;
        typ            = '0;
        pairs          = '0;
        two_pairs      = '0;

        if (i_first) begin
            n_byte_index   = '0;
            n_struct_start = '0;
            n_struct_len   = '0;
            n_struct_type  = '0;
            n_low_hold     = '0;
            n_stopped      = 1'b0;
            n_flags_seen   = 1'b0;
            n_conn         = 1'b0;
            n_maker_seen   = 1'b0;
            n_id_valid     = 1'b0;
            n_maker_id     = '0;
            n_total_len    = (i_plen > PLEN_MAX) ? PLEN_MAX : i_plen;
        end

        if (i_first && n_total_len == 8'd0) begin
            // empty payload: summary with everything zero
            sum_hit = 1'b1;
        end else if (n_byte_index < n_total_len) begin
            p   = n_byte_index;
            rel = p - n_struct_start;
            if (!n_stopped) begin
                if (rel == 8'd0) begin
                    if (i_data == 8'd0 || ({1'b0, p} + {1'b0, i_data}) >= {1'b0, n_total_len})
                        n_stopped = 1'b1;
                    else
                        n_struct_len = i_data;
                end else begin
                    typ = (rel == 8'd1) ? i_data : n_struct_type;
                    if (rel == 8'd1) begin
                        n_struct_type = i_data;
                        // short structures still count as the first of their type
                        if (typ == bleadp_pkg::AD_TYPE_FLAGS && !n_flags_seen
                            && n_struct_len < 8'd2)
                            n_flags_seen = 1'b1;
                        if (typ == bleadp_pkg::AD_TYPE_MAKER && !n_maker_seen
                            && n_struct_len < 8'd3)
                            n_maker_seen = 1'b1;
                    end else begin
                        if (typ == bleadp_pkg::AD_TYPE_FLAGS && !n_flags_seen
                            && rel == 8'd2) begin
                            n_conn       = i_data[1];
                            n_flags_seen = 1'b1;
                        end
                        if (typ == bleadp_pkg::AD_TYPE_MAKER && !n_maker_seen) begin
                            if (rel == 8'd2) begin
                                n_low_hold = i_data;
                            end else if (rel == 8'd3) begin
                                n_maker_id   = {i_data, n_low_hold};
                                n_id_valid   = 1'b1;
                                n_maker_seen = 1'b1;
                            end
                        end
                        if (typ == bleadp_pkg::AD_TYPE_UUID16_INC
                            || typ == bleadp_pkg::AD_TYPE_UUID16_ALL) begin
                            pairs     = (n_struct_len - 8'd1) >> 1;
                            two_pairs = {pairs, 1'b0};
                            if (!rel[0] && {1'b0, rel} <= two_pairs) begin
                                n_low_hold = i_data;
                            end else if (rel[0] && {1'b0, rel} <= two_pairs + 9'd1) begin
                                uuid_hit = 1'b1;
                                uuid_res.kind       = bleadp_pkg::KIND_UUID;
                                uuid_res.uuid_value = {i_data, n_low_hold};
                            end
                        end
                    end
                    if (rel == n_struct_len)
                        n_struct_start = p + 8'd1;
                end
            end
            n_byte_index = p + 8'd1;
            if (n_byte_index == n_total_len)
                sum_hit = 1'b1;
        end

        sum_res.kind           = bleadp_pkg::KIND_SUMMARY;
        sum_res.end_of_payload = 1'b1;
        sum_res.connectable    = n_conn;
        sum_res.company_valid  = n_id_valid;
        sum_res.company_id     = n_id_valid ? n_maker_id : 16'd0;

        o_push.cnt = {1'b0, uuid_hit} + {1'b0, sum_hit};
        o_push.r0  = uuid_hit ? uuid_res : sum_res;
        o_push.r1  = sum_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index   <= '0;
            r_total_len    <= '0;
            r_struct_start <= '0;
            r_struct_len   <= '0;
            r_struct_type  <= '0;
            r_low_hold     <= '0;
            r_stopped      <= 1'b0;
            r_flags_seen   <= 1'b0;
            r_conn         <= 1'b0;
            r_maker_seen   <= 1'b0;
            r_id_valid     <= 1'b0;
            r_maker_id     <= '0;
        end else if (i_go) begin
            r_byte_index   <= n_byte_index;
            r_total_len    <= n_total_len;
            r_struct_start <= n_struct_start;
            r_struct_len   <= n_struct_len;
            r_struct_type  <= n_struct_type;
            r_low_hold     <= n_low_hold;
            r_stopped      <= n_stopped;
            r_flags_seen   <= n_flags_seen;
            r_conn         <= n_conn;
            r_maker_seen   <= n_maker_seen;
            r_id_valid     <= n_id_valid;
            r_maker_id     <= n_maker_id;
        end
    end

endmodule

// ===== hdl/bleadp_rfifo.sv =====
// ----------------------------------------------------------------------------
// bleadp_rfifo
// Result queue: takes up to two results per cycle, hands out one per
// transaction on the output stream.
// ----------------------------------------------------------------------------
module bleadp_rfifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bleadp_pkg::t_push   i_push,
    input  logic                i_pop,
    output logic                o_room2,
    output logic                o_valid,
    output bleadp_pkg::t_result o_head
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    bleadp_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PW:0]   r_count,  n_count;
    logic          pop_ok;
    logic [PW:0]   free_slots;

    assign pop_ok     = i_pop && (r_count != '0);
    assign free_slots = (PW+1)'(DEPTH) - r_count + {{PW{1'b0}}, pop_ok};
    assign o_room2    = free_slots >= (PW+1)'(2);
    assign o_valid    = r_count != '0;
    assign o_head     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(i_push.cnt);
        n_rd_ptr = r_rd_ptr + {{(PW-1){1'b0}}, pop_ok};
        n_count  = r_count + (PW+1)'(i_push.cnt) - {{PW{1'b0}}, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0)
            r_mem[r_wr_ptr] <= i_push.r0;
        if (i_push.cnt == 2'd2)
            r_mem[r_wr_ptr + PW'(1)] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hdl/ble_adv_data_parser.sv =====
// ----------------------------------------------------------------------------
// ble_adv_data_parser
// Walks BLE advertising data one byte per transaction; emits 16-bit service
// UUIDs and an end-of-payload summary (connectable flag, company ID).
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one payload byte per transaction with the payload length
//   and a first-byte flag in tuser. m_axis returns results: tuser is the kind
//   (0 UUID, 1 summary), tlast marks the summary, the last result of a
//   payload. A byte yields zero, one or two results.
//   A result is offered on m_axis once its byte has left the input register
//   and the walk logic has written the result into the result queue; it
//   is held at the queue head until m_axis takes it.
//   Throughput: one byte per cycle while m_axis keeps up; the output side
//   moves one result per cycle, so the two results of one byte leave one
//   after the other. The four-entry result queue sets when s_axis_tready drops:
//   the walk step needs room for two results.
//   Reset (synchronous, active low) clears the walk state and the queue;
//   bytes without the first flag are dropped until a payload starts.
//   When m_axis stalls, the queue fills and then s_axis_tready goes low; no
//   result is lost or repeated.
// ----------------------------------------------------------------------------
module ble_adv_data_parser #(
    parameter int PAYLOAD_MAX = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] payload_length
    input  logic        s_axis_tuser,   // [0] first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] uuid_value, [16] connectable, [17] company_valid,
    // [33:18] company_id, [39:34] zero
    output logic [bleadp_pkg::RES_TDATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast    // end_of_payload
);

    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic [7:0]  r_in_plen;
    logic        r_in_first;
    logic        go;
    logic        room2;
    bleadp_pkg::t_push   push;
    bleadp_pkg::t_result head;

    assign go            = r_in_valid && room2;
    assign s_axis_tready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data  <= s_axis_tdata[7:0];
            r_in_plen  <= s_axis_tdata[15:8];
            r_in_first <= s_axis_tuser;
        end
    end

    bleadp_walker #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_data  (r_in_data),
        .i_plen  (r_in_plen),
        .i_first (r_in_first),
        .o_push  (push)
    );

    bleadp_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (go ? push : '0),
        .i_pop   (m_axis_tready),
        .o_room2 (room2),
        .o_valid (m_axis_tvalid),
        .o_head  (head)
    );

    assign m_axis_tdata = {6'd0, head.company_id, head.company_valid,
                           head.connectable, head.uuid_value};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.end_of_payload;

endmodule

// ===== hdl/bleadp_checker.sv =====
// ----------------------------------------------------------------------------
// bleadp_checker
// Port-level checks on the result stream of the parser.
// ----------------------------------------------------------------------------
module bleadp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [bleadp_pkg::RES_TDATA_W-1:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // only the summary closes a payload
    a_last_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("tlast and kind disagree");

    // UUID results carry nothing but the UUID
    a_uuid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[39:16] == 24'd0)
        else $error("UUID transaction with summary fields set");

    // summary: no UUID, and no company ID unless it is marked valid
    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[39:34] == 6'd0
            && (m_axis_tdata[17] || m_axis_tdata[33:18] == 16'd0))
        else $error("malformed summary transaction");

endmodule

bind ble_adv_data_parser bleadp_checker u_bleadp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ble_adv_data_parser. Advertising payloads go in one
// byte per transaction: a few hand-built ones first, then random ones, mostly
// well-formed AD structures with random content and some broken, cut short,
// padded or with a drifting length. An in-bench walker predicts the UUID and
// summary results. The monitor compares each result field by field. Both
// sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PAYLOAD_MAX = 255;
    localparam int BYTE_TARGET = 1150;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] payload_length;
        logic       first;
    } t_adv_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [7:0] data_byte, [15:8] payload_length
    logic        s_axis_tuser = 1'b0;   // [0] first
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] uuid_value, [16] connectable, [17] company_valid, [33:18] company_id
    logic [bleadp_pkg::RES_TDATA_W-1:0] m_axis_tdata;
    logic        m_axis_tuser;          // [0] kind
    logic        m_axis_tlast;          // end_of_payload

    ble_adv_data_parser #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    t_adv_byte           byte_q[$];
    bleadp_pkg::t_result expected_q[$];
    t_adv_byte           cur_byte;
    bleadp_pkg::t_result want;
    bleadp_pkg::t_result got;

    int err_count = 0;
    int bytes_taken = 0;
    int payload_starts = 0;
    int uuid_checked = 0;
    int summary_checked = 0;
    int cycle_cnt = 0;
    int tx_gap = 0;
    int rx_stall = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    // walker state
    logic [7:0]  pos = '0;
    logic [7:0]  total = '0;
    logic [7:0]  seg_start = '0;
    logic [7:0]  seg_len = '0;
    logic [7:0]  seg_type = '0;
    logic [7:0]  lo_hold = '0;
    logic        stopped = 1'b0;
    logic        flags_done = 1'b0;
    logic        conn_bit = 1'b0;
    logic        maker_done = 1'b0;
    logic        id_ok = 1'b0;
    logic [15:0] maker_word = '0;

    function automatic bleadp_pkg::t_result make_result(logic kind, logic [15:0] uuid,
                                                        logic conn, logic ok,
                                                        logic [15:0] id);
        bleadp_pkg::t_result r;
        r.kind           = kind;
        r.uuid_value     = uuid;
        r.connectable    = conn;
        r.company_valid  = ok;
        r.company_id     = id;
        r.end_of_payload = (kind == bleadp_pkg::KIND_SUMMARY);
        return r;
    endfunction

    // advance the AD structure walk by one byte, queue what it yields
    function automatic void walk_adv_byte(t_adv_byte b);
        int unsigned plen;
        int unsigned p;
        int unsigned rel;
        int unsigned len;
        int unsigned typ;
        int unsigned pairs;
        logic [7:0]  d;
        d    = b.data_byte;
        plen = b.payload_length;
        if (b.first) begin
            pos        = '0;
            seg_start  = '0;
            seg_len    = '0;
            seg_type   = '0;
            lo_hold    = '0;
            stopped    = 1'b0;
            flags_done = 1'b0;
            conn_bit   = 1'b0;
            maker_done = 1'b0;
            id_ok      = 1'b0;
            maker_word = '0;
            if (plen > PAYLOAD_MAX)
                plen = PAYLOAD_MAX;
            total = plen[7:0];
            if (plen == 0) begin
                expected_q.push_back(make_result(bleadp_pkg::KIND_SUMMARY, '0, 1'b0,
                                                 1'b0, '0));
                return;
            end
        end
        if (pos >= total)
            return;

        p = pos;
        if (!stopped) begin
            rel = p - seg_start;
            if (rel == 0) begin
                // zero length or a structure running past the end halts the walk
                if (d == 0 || p + d >= total)
                    stopped = 1'b1;
                else
                    seg_len = d;
            end else begin
                len = seg_len;
                typ = seg_type;
                if (rel == 1) begin
                    seg_type = d;
                    typ      = d;
                    if (typ == bleadp_pkg::AD_TYPE_FLAGS && !flags_done && len < 2)
                        flags_done = 1'b1;
                    if (typ == bleadp_pkg::AD_TYPE_MAKER && !maker_done && len < 3)
                        maker_done = 1'b1;
                end else begin
                    if (typ == bleadp_pkg::AD_TYPE_FLAGS && !flags_done && rel == 2) begin
                        conn_bit   = d[1];
                        flags_done = 1'b1;
                    end
                    if (typ == bleadp_pkg::AD_TYPE_MAKER && !maker_done) begin
                        if (rel == 2) begin
                            lo_hold = d;
                        end else if (rel == 3) begin
                            maker_word = {d, lo_hold};
                            id_ok      = 1'b1;
                            maker_done = 1'b1;
                        end
                    end
                    if (typ == bleadp_pkg::AD_TYPE_UUID16_INC
                        || typ == bleadp_pkg::AD_TYPE_UUID16_ALL) begin
                        pairs = (len - 1) / 2;
                        if (rel % 2 == 0 && rel <= 2 * pairs)
                            lo_hold = d;
                        else if (rel % 2 == 1 && rel <= 1 + 2 * pairs)
                            expected_q.push_back(make_result(bleadp_pkg::KIND_UUID,
                                                             {d, lo_hold},
                                                             1'b0, 1'b0, '0));
                    end
                end
                if (rel == len)
                    seg_start = 8'(p + 1);
            end
        end
        pos = 8'(p + 1);

        if (pos == total)
            expected_q.push_back(make_result(bleadp_pkg::KIND_SUMMARY, '0, conn_bit,
                                             id_ok, id_ok ? maker_word : 16'h0000));
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // n_send bytes; past the body end the data is random, skew scrambles later lengths
    task automatic send_payload(logic [7:0] body[$], logic [7:0] plen, int n_send,
                                bit skew);
        t_adv_byte b;
        payload_starts++;
        for (int i = 0; i < n_send; i++) begin
            b.data_byte      = (i < body.size()) ? body[i] : 8'($urandom_range(0, 255));
            b.payload_length = (i == 0 || !skew) ? plen : 8'($urandom_range(0, 255));
            b.first          = (i == 0);
            byte_q.push_back(b);
        end
    endtask

    task automatic queue_stray_byte();
        t_adv_byte b;
        b.data_byte      = 8'($urandom_range(0, 255));
        b.payload_length = 8'($urandom_range(0, 255));
        b.first          = 1'b0;
        byte_q.push_back(b);
    endtask

    task automatic gen_payload();
        logic [7:0] body[$];
        logic [7:0] ty;
        int r;
        int plen;
        int room;
        int slen;
        int n_send;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            send_payload(body, 8'd0, 1, 1'b0);
            return;
        end
        if (r < 85)
            plen = $urandom_range(1, 31);
        else if (r < 95)
            plen = $urandom_range(32, 127);
        else
            plen = $urandom_range(128, 255);

        while (body.size() < plen) begin
            room = plen - body.size();
            if (room < 2 || $urandom_range(0, 29) == 0) begin
                // zero length or an overrunning length byte
                if ($urandom_range(0, 2) == 0)
                    body.push_back(8'h00);
                else
                    body.push_back(8'($urandom_range(room, 255)));
            end else begin
                slen = $urandom_range(1, (room - 1 < 30) ? room - 1 : 30);
                case ($urandom_range(0, 5))
                    0:       ty = bleadp_pkg::AD_TYPE_FLAGS;
                    1:       ty = bleadp_pkg::AD_TYPE_UUID16_INC;
                    2:       ty = bleadp_pkg::AD_TYPE_UUID16_ALL;
                    3, 4:    ty = bleadp_pkg::AD_TYPE_MAKER;
                    default: ty = 8'($urandom_range(0, 255));
                endcase
                // UUID lists are mostly whole pairs
                if ((ty == bleadp_pkg::AD_TYPE_UUID16_INC
                     || ty == bleadp_pkg::AD_TYPE_UUID16_ALL) &&
                    slen % 2 == 0 && $urandom_range(0, 3) != 0)
                    slen--;
                body.push_back(8'(slen));
                body.push_back(ty);
                repeat (slen - 1) body.push_back(8'($urandom_range(0, 255)));
            end
        end

        r = $urandom_range(0, 99);
        n_send = plen;
        if (r < 8)
            n_send = $urandom_range(1, plen);          // next payload restarts it
        else if (r >= 16 && r < 22)
            n_send = plen + $urandom_range(1, 3);      // trailing bytes outside payload
        send_payload(body, 8'(plen), n_send, r >= 8 && r < 16);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                walk_adv_byte(cur_byte);
                bytes_taken++;
            end
            if ($urandom_range(0, 149) == 0)
                tx_calm = !tx_calm;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    cur_byte = byte_q.pop_front();
                    s_axis_tdata  <= {cur_byte.payload_length, cur_byte.data_byte};
                    s_axis_tuser  <= cur_byte.first;
                    s_axis_tvalid <= 1'b1;
                    tx_gap = pick_gap(tx_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = make_result(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[16],
                                  m_axis_tdata[17], m_axis_tdata[33:18]);
                got.end_of_payload = m_axis_tlast;
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected: kind %0d uuid %h", got.kind,
                           got.uuid_value);
                    err_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.kind != want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                        err_count++;
                    end
                    if (got.uuid_value != want.uuid_value) begin
                        $error("uuid_value: expected %h, actual %h", want.uuid_value,
                               got.uuid_value);
                        err_count++;
                    end
                    if (got.connectable != want.connectable) begin
                        $error("connectable: expected %0d, actual %0d", want.connectable,
                               got.connectable);
                        err_count++;
                    end
                    if (got.company_valid != want.company_valid) begin
                        $error("company_valid: expected %0d, actual %0d",
                               want.company_valid, got.company_valid);
                        err_count++;
                    end
                    if (got.company_id != want.company_id) begin
                        $error("company_id: expected %h, actual %h", want.company_id,
                               got.company_id);
                        err_count++;
                    end
                    if (got.end_of_payload != want.end_of_payload) begin
                        $error("end_of_payload: expected %0d, actual %0d",
                               want.end_of_payload, got.end_of_payload);
                        err_count++;
                    end
                    if (want.kind == bleadp_pkg::KIND_SUMMARY)
                        summary_checked++;
                    else
                        uuid_checked++;
                end
            end
            if ($urandom_range(0, 149) == 0)
                rx_calm = !rx_calm;
            if (rx_stall == 0 && $urandom_range(0, 3) == 0)
                rx_stall = pick_gap(rx_calm);
            if (rx_stall != 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     expected_q.size());
            $display("** ble_adv_data_parser: FAILED **");
            $finish;
        end
    end

    initial begin
        // stray byte before any payload
        queue_stray_byte();
        // empty payload
        send_payload('{8'hFF}, 8'd0, 1, 1'b0);
        // flags (connectable), one UUID, manufacturer ID
        send_payload('{8'h02, bleadp_pkg::AD_TYPE_FLAGS, 8'h06,
                       8'h03, bleadp_pkg::AD_TYPE_UUID16_ALL, 8'h0D, 8'h18,
                       8'h03, bleadp_pkg::AD_TYPE_MAKER, 8'h4C, 8'h00},
                     8'd11, 11, 1'b0);
        // flags with no data, short manufacturer, odd UUID byte, zero length at end;
        // length on later bytes drifts
        send_payload('{8'h01, bleadp_pkg::AD_TYPE_FLAGS,
                       8'h02, bleadp_pkg::AD_TYPE_MAKER, 8'h59,
                       8'h04, bleadp_pkg::AD_TYPE_UUID16_INC, 8'hAA, 8'hBB, 8'hCC,
                       8'h00}, 8'd11, 11, 1'b1);
        // restart in the middle of a payload
        send_payload('{8'h05, bleadp_pkg::AD_TYPE_UUID16_ALL}, 8'd6, 2, 1'b0);
        // structure overrunning the end, then a byte after completion
        send_payload('{8'h03, bleadp_pkg::AD_TYPE_UUID16_ALL, 8'h34, 8'h12, 8'h09,
                       8'hFF}, 8'd6, 6, 1'b0);
        queue_stray_byte();

        while (byte_q.size() < BYTE_TARGET)
            gen_payload();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d bytes over %0d payload starts, random idling on both sides",
                 bytes_taken, payload_starts);
        $display("checked %0d UUID results and %0d summaries, %0d mismatches",
                 uuid_checked, summary_checked, err_count);
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("** ble_adv_data_parser: PASSED **");
        end else begin
            $display("** ble_adv_data_parser: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bleadp_pkg.sv
hdl/bleadp_walker.sv
hdl/bleadp_rfifo.sv
hdl/ble_adv_data_parser.sv
hdl/bleadp_checker.sv
sim/tb_top.sv
